/* src/ps2scd_pkg.sv */
// Shared constants and types for the PS/2 scan code set 1 decoder.
// No dependencies; used by every module of the block but the RAM.
`timescale 1ns / 1ps
`default_nettype none
package ps2scd_pkg;

  localparam int KEYMAP_DEPTH = 1024;
  localparam int KEYMAP_AW    = $clog2(KEYMAP_DEPTH);
  localparam int KEY_COUNT    = 256;
  localparam int CHAR_W       = 8;

  // item commands
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

  // result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_HOST = 1'b1;

  // keyboard bytes
  localparam logic [7:0] BYTE_ACK     = 8'hFA;
  localparam logic [7:0] BYTE_RESEND  = 8'hFE;
  localparam logic [7:0] BYTE_PREFIX0 = 8'hE0;
  localparam logic [7:0] BYTE_PREFIX1 = 8'hE1;
  localparam logic [7:0] CODE_CAPS    = 8'h3A;
  localparam logic [7:0] CODE_NUM     = 8'h45;
  localparam logic [7:0] CODE_SCROLL  = 8'h46;
  localparam logic [7:0] LED_COMMAND  = 8'hED;

  // key state entries that pick the keymap plane
  localparam logic [7:0] KEY_LSHIFT = 8'h2A;
  localparam logic [7:0] KEY_RSHIFT = 8'h36;
  localparam logic [7:0] KEY_RALT   = 8'hB8;

  // word handed from the decode stage to the result stage
  typedef struct packed {
    logic       valid;
    logic       led;   // lock key: two host words, else a keymap character
    logic [2:0] mask;  // caps, num, scroll after the toggle
  } issue_t;

endpackage
`default_nettype wire

/* src/ps2_scan_code_decoder_core.sv */
// PS/2 scan code set 1 decoder, top level.
// Channels: an input channel (valid/ready) carries either a keyboard byte
// (command 0, scan_byte) or a keymap write (command 1, map_index, map_value).
// The result channel (res_valid/res_ready) carries out_kind, out_byte and last:
// a decoded character (kind 0) or a byte for the keyboard (kind 1).
// Path: a character word reaches res_valid through the keymap read register,
// loaded at the accepting edge, and then the output register.
// A lock key gives the LED command word, then the mask word once that is taken.
// Throughput: one word per cycle while results drain; the keymap read port
// and the single read stage set this. A lock key holds the result side for
// two words, so input stalls while the mask word waits if another result follows.
// Reset: key state, lock flags and prefix clear at once; the keymap is then
// swept to zero, one entry a cycle, across every entry with ready held low.
// Stalls: with res_ready low, one finished word waits in the output register
// and one more sits in the read stage; ready drops after that.
// Depends on ps2scd_pkg, ps2scd_ram, ps2scd_decode, ps2scd_emit.
`timescale 1ns / 1ps
`default_nettype none
module ps2_scan_code_decoder_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             valid,
  output      logic                             ready,
  input  wire logic                             command,
  input  wire logic [7:0]                       scan_byte,
  input  wire logic [ps2scd_pkg::KEYMAP_AW-1:0] map_index,
  input  wire logic [ps2scd_pkg::CHAR_W-1:0]    map_value,
  output      logic                             res_valid,
  input  wire logic                             res_ready,
  output      logic                             out_kind,
  output      logic [7:0]                       out_byte,
  output      logic                             last
);

  ps2scd_pkg::issue_t               issue;
  logic                             slot_free;
  logic                             ram_we, ram_re;
  logic [ps2scd_pkg::KEYMAP_AW-1:0] ram_waddr, ram_raddr;
  logic [ps2scd_pkg::CHAR_W-1:0]    ram_wdata, ram_rdata;

  // decode: classify the word, update key and lock state, address the keymap
  ps2scd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .valid     (valid),
    .ready     (ready),
    .command   (command),
    .scan_byte (scan_byte),
    .map_index (map_index),
    .map_value (map_value),
    .slot_free (slot_free),
    .issue     (issue),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  // keymap: four planes of 256 characters; read data held until the next read
  ps2scd_ram #(
    .WIDTH (ps2scd_pkg::CHAR_W),
    .DEPTH (ps2scd_pkg::KEYMAP_DEPTH)
  ) u_keymap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // emit: drop empty keymap entries, sequence the two LED words
  ps2scd_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .rdata     (ram_rdata),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule
`default_nettype wire

/* src/ps2scd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ps2scd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/ps2scd_decode.sv */
// Input stage: classifies words, keeps key, lock and prefix state, drives the keymap port.
// Depends on ps2scd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ps2scd_decode (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           valid,
  output      logic                           ready,
  input  wire logic                           command,
  input  wire logic [7:0]                     scan_byte,
  input  wire logic [ps2scd_pkg::KEYMAP_AW-1:0] map_index,
  input  wire logic [ps2scd_pkg::CHAR_W-1:0]  map_value,
  input  wire logic                           slot_free,
  output      ps2scd_pkg::issue_t             issue,
  output      logic                           ram_we,
  output      logic [ps2scd_pkg::KEYMAP_AW-1:0] ram_waddr,
  output      logic [ps2scd_pkg::CHAR_W-1:0]  ram_wdata,
  output      logic                           ram_re,
  output      logic [ps2scd_pkg::KEYMAP_AW-1:0] ram_raddr
);

  logic                                clr_busy;
  logic [ps2scd_pkg::KEYMAP_AW-1:0]    clr_addr;
  logic [ps2scd_pkg::KEY_COUNT-1:0]    key_down;
  logic                                caps_on, num_on, scroll_on, prefix_seen;
  logic                                caps_next, num_next, scroll_next;
  logic                                acc, scan, is_skip, is_prefix, is_lock, is_make;
  logic                                shift, ralt;
  logic [7:0]                          key_idx;

  assign ready = !clr_busy && slot_free;
  assign acc   = valid && ready;
  assign scan  = (command == ps2scd_pkg::CMD_SCAN);

  assign is_skip   = (scan_byte == ps2scd_pkg::BYTE_ACK) ||
                     (scan_byte == ps2scd_pkg::BYTE_RESEND);
  assign is_prefix = (scan_byte == ps2scd_pkg::BYTE_PREFIX0) ||
                     (scan_byte == ps2scd_pkg::BYTE_PREFIX1);
  assign is_lock   = (scan_byte == ps2scd_pkg::CODE_CAPS) ||
                     (scan_byte == ps2scd_pkg::CODE_NUM) ||
                     (scan_byte == ps2scd_pkg::CODE_SCROLL);
  assign is_make   = !scan_byte[7] && !is_lock;

  assign shift = key_down[ps2scd_pkg::KEY_LSHIFT] || key_down[ps2scd_pkg::KEY_RSHIFT];
  assign ralt  = key_down[ps2scd_pkg::KEY_RALT];
  assign key_idx = {prefix_seen, scan_byte[6:0]};

  assign caps_next   = caps_on   ^ (scan_byte == ps2scd_pkg::CODE_CAPS);
  assign num_next    = num_on    ^ (scan_byte == ps2scd_pkg::CODE_NUM);
  assign scroll_next = scroll_on ^ (scan_byte == ps2scd_pkg::CODE_SCROLL);

  // plane select is the upper address bits: shift adds 256, right alt 512
  assign ram_re    = acc && scan && is_make;
  assign ram_raddr = {ralt, shift, scan_byte};
  assign ram_we    = clr_busy || (acc && !scan);
  assign ram_waddr = clr_busy ? clr_addr : map_index;
  assign ram_wdata = clr_busy ? '0 : map_value;

  always_comb begin
    issue.valid = acc && scan && (is_lock || is_make);
    issue.led   = is_lock;
    issue.mask  = {caps_next, num_next, scroll_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy    <= 1'b1;
      clr_addr    <= '0;
      key_down    <= '0;
      caps_on     <= 1'b0;
      num_on      <= 1'b0;
      scroll_on   <= 1'b0;
      prefix_seen <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + ps2scd_pkg::KEYMAP_AW'(1);
        if (clr_addr == ps2scd_pkg::KEYMAP_AW'(ps2scd_pkg::KEYMAP_DEPTH - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (acc && scan && !is_skip) begin
        if (is_prefix) begin
          prefix_seen <= 1'b1;
        end else if (is_lock) begin
          caps_on   <= caps_next;
          num_on    <= num_next;
          scroll_on <= scroll_next;
        end else begin
          key_down[key_idx] <= !scan_byte[7];
          prefix_seen       <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* src/ps2scd_emit.sv */
// Result stage: waits for keymap read data, drops empty entries, sequences LED words.
// Depends on ps2scd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ps2scd_emit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ps2scd_pkg::issue_t            issue,
  input  wire logic [ps2scd_pkg::CHAR_W-1:0] rdata,
  output      logic                          slot_free,
  output      logic                          res_valid,
  input  wire logic                          res_ready,
  output      logic                          out_kind,
  output      logic [7:0]                    out_byte,
  output      logic                          last
);

  logic       s1_valid, s1_led;
  logic [2:0] s1_mask;
  logic       pend_valid;
  logic [2:0] pend_mask;
  logic       s1_drop, out_free, s1_leave;

  assign s1_drop   = s1_valid && !s1_led && (rdata == '0);
  assign out_free  = (!res_valid || res_ready) && !pend_valid;
  assign s1_leave  = s1_valid && (s1_drop || out_free);
  assign slot_free = !s1_valid || s1_leave;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (slot_free) begin
        s1_valid <= issue.valid;
        s1_led   <= issue.led;
        s1_mask  <= issue.mask;
      end
      if (pend_valid && res_ready) begin
        // second host word: the LED mask
        res_valid  <= 1'b1;
        out_kind   <= ps2scd_pkg::KIND_HOST;
        out_byte   <= {5'b0, pend_mask};
        last       <= 1'b1;
        pend_valid <= 1'b0;
      end else if (s1_leave && !s1_drop) begin
        res_valid <= 1'b1;
        if (s1_led) begin
          out_kind   <= ps2scd_pkg::KIND_HOST;
          out_byte   <= ps2scd_pkg::LED_COMMAND;
          last       <= 1'b0;
          pend_valid <= 1'b1;
          pend_mask  <= s1_mask;
        end else begin
          out_kind <= ps2scd_pkg::KIND_CHAR;
          out_byte <= rdata;
          last     <= 1'b1;
        end
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_pend_behind_cmd: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (res_valid && !last && out_kind == ps2scd_pkg::KIND_HOST &&
                    out_byte == ps2scd_pkg::LED_COMMAND))
    else $error("LED mask pending without the LED command word in front");
  a_not_last_pend: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !last) |-> pend_valid)
    else $error("non-final word shown with no follow-up pending");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    issue.valid |-> slot_free)
    else $error("word issued while the read stage is occupied");
  a_mask_follows: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && res_ready) |=> (res_valid && last && out_byte[7:3] == '0))
    else $error("LED mask word did not follow the command word");
`endif

endmodule
`default_nettype wire

/* dv/ps2_scan_code_decoder_checker.sv */
// Checker for the PS/2 scan code set 1 decoder: watches both channels, keeps
// its own copy of key state, lock flags and keymap, and compares result words.
// Depends on ps2scd_pkg.
`timescale 1ns / 1ps
module ps2_scan_code_decoder_checker
  import ps2scd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid,
  input  logic                  ready,
  input  logic                  command,
  input  logic [7:0]            scan_byte,
  input  logic [KEYMAP_AW-1:0]  map_index,
  input  logic [CHAR_W-1:0]     map_value,
  input  logic                  res_valid,
  input  logic                  res_ready,
  input  logic                  out_kind,
  input  logic [7:0]            out_byte,
  input  logic                  last,
  input  logic                  end_check,
  output int                    errors,
  output int                    pending,
  output int                    words_checked
);

  typedef struct {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } result_word_t;

  result_word_t         led_char_words[$];
  result_word_t         head;
  logic [KEY_COUNT-1:0] held_keys;
  logic [CHAR_W-1:0]    map_mem [KEYMAP_DEPTH];
  logic                 caps_lock, num_lock, scroll_lock, after_prefix;
  int                   err_tally = 0;
  int                   checked_tally = 0;
  logic                 end_reported = 1'b0;

  function automatic result_word_t make_word(logic kind, logic [7:0] data, logic fin);
    result_word_t w;
    w.kind = kind;
    w.data = data;
    w.last = fin;
    return w;
  endfunction

  // Work out the result words one accepted input word causes.
  task automatic decode_scan(input logic cmd, input logic [7:0] code,
                             input logic [KEYMAP_AW-1:0] idx,
                             input logic [CHAR_W-1:0] val);
    logic [KEYMAP_AW-1:0] addr;
    logic                 shift, ralt;
    logic [7:0]           key;
    if (cmd == CMD_MAP) begin
      map_mem[idx] = val;
      return;
    end
    if (code == BYTE_ACK || code == BYTE_RESEND) return;
    if (code == BYTE_PREFIX0 || code == BYTE_PREFIX1) begin
      after_prefix = 1'b1;
      return;
    end
    if (code == CODE_CAPS || code == CODE_NUM || code == CODE_SCROLL) begin
      if (code == CODE_CAPS) caps_lock = ~caps_lock;
      else if (code == CODE_NUM) num_lock = ~num_lock;
      else scroll_lock = ~scroll_lock;
      led_char_words.push_back(make_word(KIND_HOST, LED_COMMAND, 1'b0));
      led_char_words.push_back(make_word(KIND_HOST, {5'd0, caps_lock, num_lock, scroll_lock},
                                         1'b1));
      return;
    end
    if (!code[7]) begin
      shift = held_keys[KEY_LSHIFT] | held_keys[KEY_RSHIFT];
      ralt  = held_keys[KEY_RALT];
      addr  = {ralt, shift, code};
      if (map_mem[addr] != '0)
        led_char_words.push_back(make_word(KIND_CHAR, map_mem[addr], 1'b1));
    end
    key = {after_prefix, code[6:0]};
    held_keys[key] = ~code[7];
    after_prefix = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_keys = '0;
      for (int i = 0; i < KEYMAP_DEPTH; i++) map_mem[i] = '0;
      caps_lock = 1'b0;
      num_lock = 1'b0;
      scroll_lock = 1'b0;
      after_prefix = 1'b0;
      led_char_words.delete();
    end else begin
      if (valid && ready) decode_scan(command, scan_byte, map_index, map_value);
      if (res_valid && res_ready) begin
        if (led_char_words.size() == 0) begin
          $error("unexpected result word: out_kind %0d out_byte %02h last %0d",
                 out_kind, out_byte, last);
          err_tally++;
        end else begin
          head = led_char_words.pop_front();
          checked_tally++;
          if (out_kind !== head.kind) begin
            $error("out_kind: expected %0d, got %0d", head.kind, out_kind);
            err_tally++;
          end
          if (out_byte !== head.data) begin
            $error("out_byte: expected %02h, got %02h", head.data, out_byte);
            err_tally++;
          end
          if (last !== head.last) begin
            $error("last: expected %0d, got %0d", head.last, last);
            err_tally++;
          end
        end
      end
      if (end_check && !end_reported) begin
        end_reported = 1'b1;
        if (led_char_words.size() != 0) begin
          $error("%0d expected result words never arrived", led_char_words.size());
          err_tally++;
        end
      end
    end
    errors <= err_tally;
    pending <= led_char_words.size();
    words_checked <= checked_tally;
  end

endmodule

/* dv/ps2_scan_code_decoder_core_tb.sv */
// Top of the PS/2 scan code set 1 decoder bench: clock, reset, stimulus and verdict.
// Depends on ps2scd_pkg, ps2_scan_code_decoder_core and ps2_scan_code_decoder_checker.
`timescale 1ns / 1ps
module ps2_scan_code_decoder_core_tb;
  import ps2scd_pkg::*;

  localparam int LIMIT        = 400000; // covers the keymap sweep and every stall, many times over
  localparam int RANDOM_ITEMS = 525;
  localparam int PHASES       = 5;
  localparam int DRAIN_CYCLES = 8;      // margin for words still in the keymap read and output registers

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 valid = 1'b0;
  logic                 ready;
  logic                 command = CMD_SCAN;
  logic [7:0]           scan_byte = '0;
  logic [KEYMAP_AW-1:0] map_index = '0;
  logic [CHAR_W-1:0]    map_value = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  logic                 out_kind;
  logic [7:0]           out_byte;
  logic                 last;
  logic                 end_check = 1'b0;

  int errors, pending, words_checked;
  int send_idle = 0;   // percentage of cycles the sender holds back
  int recv_stall = 0;  // percentage of cycles the receiver holds res_ready low
  int cycles = 0;
  int counted = 0;     // input words the block acts on (ack and resend bytes excluded)
  int map_writes = 0;

  ps2_scan_code_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .valid     (valid),
    .ready     (ready),
    .command   (command),
    .scan_byte (scan_byte),
    .map_index (map_index),
    .map_value (map_value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .last      (last)
  );

  ps2_scan_code_decoder_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .valid         (valid),
    .ready         (ready),
    .command       (command),
    .scan_byte     (scan_byte),
    .map_index     (map_index),
    .map_value     (map_value),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .out_kind      (out_kind),
    .out_byte      (out_byte),
    .last          (last),
    .end_check     (end_check),
    .errors        (errors),
    .pending       (pending),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result side at random, one decision per edge.
  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_stall);
  end

  // Guard against a hung block: give up well beyond the slowest correct run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one word and hold it until taken. Valid stays high from one word to
  // the next unless the sender chooses to idle, so it is never dropped and
  // raised in the same step.
  task automatic drive_word(input logic cmd, input logic [7:0] sb,
                            input logic [KEYMAP_AW-1:0] idx, input logic [CHAR_W-1:0] val);
    if ($urandom_range(99) < send_idle) begin
      valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    valid     <= 1'b1;
    command   <= cmd;
    scan_byte <= sb;
    map_index <= idx;
    map_value <= val;
    do @(posedge clk); while (!ready);
    if (cmd == CMD_MAP) map_writes++;
    if (cmd == CMD_MAP || (sb != BYTE_ACK && sb != BYTE_RESEND)) counted++;
  endtask

  // Keyboard byte; the keymap fields carry noise the block must ignore.
  task automatic scan(input logic [7:0] code);
    drive_word(CMD_SCAN, code, KEYMAP_AW'($urandom_range(KEYMAP_DEPTH - 1)),
               CHAR_W'($urandom_range(255)));
  endtask

  // Keymap write; scan_byte carries noise.
  task automatic map_write(input logic [KEYMAP_AW-1:0] idx, input logic [CHAR_W-1:0] val);
    drive_word(CMD_MAP, 8'($urandom_range(255)), idx, val);
  endtask

  // Let every outstanding result word drain with the sender quiet.
  task automatic hold_until_drained();
    valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // One random step of typing: mostly realistic key traffic with modifiers held
  // across words, plus keymap writes aimed at the codes being typed, and noise.
  task automatic random_item();
    int         pick;
    logic [7:0] code;
    pick = $urandom_range(99);
    if (pick < 14) begin
      // Aim most writes at the low codes that the typing below draws from.
      if ($urandom_range(3) == 0)
        map_write(KEYMAP_AW'($urandom_range(KEYMAP_DEPTH - 1)), CHAR_W'($urandom_range(255)));
      else
        map_write({2'($urandom_range(3)), 8'($urandom_range(8'h3F))},
                  CHAR_W'($urandom_range(255)));
    end else if (pick < 24) begin
      case ($urandom_range(2))
        0:       code = CODE_CAPS;
        1:       code = CODE_NUM;
        default: code = CODE_SCROLL;
      endcase
      if ($urandom_range(3) == 0) code = {1'b1, code[6:0]};
      scan(code);
    end else if (pick < 36) begin
      case ($urandom_range(3))
        0:       code = KEY_LSHIFT;
        1:       code = KEY_RSHIFT;
        default: begin
          // Right alt travels behind a prefix byte.
          scan($urandom_range(1) ? BYTE_PREFIX0 : BYTE_PREFIX1);
          code = {1'b0, KEY_RALT[6:0]};
        end
      endcase
      if ($urandom_range(1)) code = {1'b1, code[6:0]};
      scan(code);
    end else if (pick < 76) begin
      if ($urandom_range(4) == 0) scan(8'($urandom_range(8'h7F)));
      else scan(8'($urandom_range(8'h3F)));
    end else if (pick < 88) begin
      scan({1'b1, 7'($urandom_range(8'h7F))});
    end else if (pick < 93) begin
      scan($urandom_range(1) ? BYTE_PREFIX0 : BYTE_PREFIX1);
      if ($urandom_range(1)) scan(8'($urandom_range(255)));
    end else if (pick < 96) begin
      scan($urandom_range(1) ? BYTE_ACK : BYTE_RESEND);
    end else begin
      scan(8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: fill all four planes for one key, then walk the special bytes,
    // the lock keys, a lock break, and each modifier combination.
    map_write('0, 8'hFF);
    map_write(KEYMAP_AW'(KEYMAP_DEPTH - 1), 8'h80);
    map_write(10'h01E, 8'h61);
    map_write(10'h11E, 8'h41);
    map_write(10'h21E, 8'h62);
    map_write(10'h31E, 8'h42);
    scan(BYTE_ACK);
    scan(BYTE_RESEND);
    scan(8'h1E);                      // plain plane
    scan(CODE_CAPS);
    scan(CODE_NUM);
    scan(CODE_SCROLL);
    scan({1'b1, CODE_CAPS[6:0]});     // lock break gives nothing
    scan(KEY_LSHIFT);
    scan(8'h1E);                      // shift plane
    scan(BYTE_PREFIX0);
    scan({1'b0, KEY_RALT[6:0]});      // right alt down
    scan(8'h1E);                      // shift and alt plane
    scan({1'b1, KEY_LSHIFT[6:0]});
    scan(8'h1E);                      // alt plane
    scan(BYTE_PREFIX1);
    scan(KEY_RALT);                   // right alt up
    scan(8'h1E);
    scan(8'h00);                      // lowest code hits entry zero
    scan(8'hFF);                      // highest byte is a break

    // Random: several idling mixes, with a full drain between them.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1:       begin send_idle = 56; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 56; end
        3:       begin send_idle = 17; recv_stall = 17; end
        default: begin send_idle = 0;  recv_stall = 0;  end
      endcase
      while (counted < 25 + (phase + 1) * RANDOM_ITEMS / PHASES) random_item();
      hold_until_drained();
    end

    send_idle = 0;
    recv_stall = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Sent %0d input words (%0d keymap writes) across %0d idling mixes.",
             counted, map_writes, PHASES);
    $display("Checked %0d result words in %0d cycles.", words_checked, cycles);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
src/ps2scd_pkg.sv
src/ps2scd_ram.sv
src/ps2scd_decode.sv
src/ps2scd_emit.sv
src/ps2_scan_code_decoder_core.sv
dv/ps2_scan_code_decoder_checker.sv
dv/ps2_scan_code_decoder_core_tb.sv
